### hdl/dhcp_pkg.sv
package dhcp_pkg;

	localparam int MaxDns = 4;
	localparam int DnsIdxW = (MaxDns > 1) ? $clog2(MaxDns) : 1;
	localparam int DnsCntW = $clog2(MaxDns + 1);

	localparam logic [31:0] Cookie = 32'h6382_5363;
	localparam logic [15:0] CookieAt = 16'd236;
	localparam logic [15:0] OptionsAt = 16'd240;

	localparam logic [7:0] OptPad = 8'd0;
	localparam logic [7:0] OptMask = 8'd1;
	localparam logic [7:0] OptRouter = 8'd3;
	localparam logic [7:0] OptDns = 8'd6;
	localparam logic [7:0] OptLease = 8'd51;
	localparam logic [7:0] OptMsgType = 8'd53;
	localparam logic [7:0] OptServerId = 8'd54;
	localparam logic [7:0] OptRenewal = 8'd58;
	localparam logic [7:0] OptRebind = 8'd59;
	localparam logic [7:0] OptEnd = 8'd255;

	localparam logic [3:0] KindStatus = 4'd0;
	localparam logic [3:0] KindMsgType = 4'd1;
	localparam logic [3:0] KindYourAddr = 4'd2;
	localparam logic [3:0] KindDns = 4'd9;

	localparam logic [1:0] StAccepted = 2'd0;
	localparam logic [1:0] StIgnored = 2'd1;
	localparam logic [1:0] StMalformed = 2'd2;

	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_VALUE,
		PH_AFTER
	} phase_t;

	// One packet summary handed from the parser to the emitter.
	typedef struct packed {
		logic [1:0] status;
		logic [31:0] your_addr;
		logic [6:0][31:0] values;
		logic [6:0] present;
		logic dns_present;
		logic [DnsCntW-1:0] dns_count;
		logic [MaxDns-1:0][31:0] dns;
	} summary_t;

	// Slot in the captured values for four-byte options, zero when none.
	function automatic logic [2:0] slot_of(input logic [7:0] code);
		logic [2:0] s;
		s = 3'd0;
		case (code)
			OptMask: s = 3'd1;
			OptRouter: s = 3'd2;
			OptServerId: s = 3'd3;
			OptLease: s = 3'd4;
			OptRenewal: s = 3'd5;
			OptRebind: s = 3'd6;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

### hdl/dhcp_parser.sv
module dhcp_parser (
	input logic clk,
	input logic arst_n,
	input logic in_beat,
	input logic [7:0] data_byte,
	input logic last,
	input logic [31:0] expected_xid,
	input logic [47:0] client_mac,
	output logic sum_valid,
	output dhcp_pkg::summary_t sum
);
	import dhcp_pkg::*;

	logic [15:0] pos_q;
	logic [2:0] hflags_q;
	logic [31:0] xid_q, yaddr_q, cookie_q, vshift_q;
	phase_t phase_q;
	logic [7:0] code_q, remain_q;
	logic [6:0][31:0] vals_q;
	logic [MaxDns-1:0][31:0] dns_q;
	logic [6:0] pres_q;
	logic dns_pres_q;
	logic [DnsCntW-1:0] dcnt_q;
	logic err_q, end_q;

	// Next values of the per-byte state.
	logic [2:0] hflags_d;
	logic [31:0] xid_d, yaddr_d, cookie_d, vshift_d;
	phase_t phase_d;
	logic [7:0] code_d, remain_d, want;
	logic [6:0][31:0] vals_d;
	logic [MaxDns-1:0][31:0] dns_d;
	logic [6:0] pres_d;
	logic dns_pres_d;
	logic [DnsCntW-1:0] dcnt_d;
	logic err_d, end_d, bad;
	logic [2:0] slot;
	logic [5:0] macsel;
	logic [1:0] status;

	always_comb begin
		hflags_d = hflags_q;
		xid_d = xid_q;
		yaddr_d = yaddr_q;
		cookie_d = cookie_q;
		vshift_d = vshift_q;
		phase_d = phase_q;
		code_d = code_q;
		remain_d = remain_q;
		vals_d = vals_q;
		dns_d = dns_q;
		pres_d = pres_q;
		dns_pres_d = dns_pres_q;
		dcnt_d = dcnt_q;
		err_d = err_q;
		end_d = end_q;
		bad = 1'b0;
		slot = slot_of(code_q);
		macsel = 6'(8 * (33 - int'(pos_q[5:0])));
		want = 8'(client_mac >> macsel);
		if (pos_q < OptionsAt) begin
			if ((pos_q == 16'd0 && data_byte != 8'd2) || (pos_q == 16'd1 && data_byte != 8'd1)
			    || (pos_q == 16'd2 && data_byte != 8'd6))
				hflags_d[0] = 1'b1;
			if (pos_q >= 16'd4 && pos_q <= 16'd7) begin
				xid_d = {xid_q[23:0], data_byte};
				if (pos_q == 16'd7 && xid_d != expected_xid) hflags_d[1] = 1'b1;
			end
			if (pos_q >= 16'd16 && pos_q <= 16'd19) yaddr_d = {yaddr_q[23:0], data_byte};
			if (pos_q >= 16'd28 && pos_q <= 16'd33 && data_byte != want) hflags_d[1] = 1'b1;
			if (pos_q >= CookieAt) begin
				cookie_d = {cookie_q[23:0], data_byte};
				if (pos_q == OptionsAt - 16'd1 && cookie_d != Cookie) hflags_d[2] = 1'b1;
			end
		end else if (!err_q) begin
			case (phase_q)
				PH_CODE: begin
					if (data_byte == OptEnd) begin
						end_d = 1'b1;
						phase_d = PH_AFTER;
					end else if (data_byte != OptPad) begin
						code_d = data_byte;
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					if (code_q == OptMsgType) begin
						bad = data_byte != 8'd1 || pres_q[0];
					end else if (code_q == OptRouter) begin
						bad = data_byte == 8'd0 || data_byte[1:0] != 2'd0 || pres_q[2];
					end else if (code_q == OptDns) begin
						bad = data_byte == 8'd0 || data_byte[1:0] != 2'd0 || dns_pres_q;
						dns_pres_d = 1'b1;
						dcnt_d = '0;
					end else if (slot != 3'd0) begin
						bad = data_byte != 8'd4 || pres_q[slot];
					end
					if (bad) begin
						err_d = 1'b1;
					end else begin
						remain_d = data_byte;
						vshift_d = '0;
						phase_d = (data_byte != 8'd0) ? PH_VALUE : PH_CODE;
					end
				end
				PH_VALUE: begin
					vshift_d = {vshift_q[23:0], data_byte};
					remain_d = remain_q - 8'd1;
					if (code_q == OptMsgType) begin
						vals_d[0] = {24'd0, data_byte};
						pres_d[0] = 1'b1;
					end else if (remain_d[1:0] == 2'd0) begin
						if (code_q == OptDns) begin
							if (int'(dcnt_q) < MaxDns) begin
								dns_d[DnsIdxW'(dcnt_q)] = vshift_d;
								dcnt_d = dcnt_q + 1'b1;
							end
						end else if (slot != 3'd0 && !pres_q[slot]) begin
							vals_d[slot] = vshift_d;
							pres_d[slot] = 1'b1;
						end
					end
					if (remain_d == 8'd0) phase_d = PH_CODE;
				end
				PH_AFTER: begin
					if (data_byte != 8'd0) err_d = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Final status in priority order.
	always_comb begin
		if (pos_q < OptionsAt - 16'd1) status = StMalformed;
		else if (hflags_d[0]) status = StIgnored;
		else if (hflags_d[2]) status = StMalformed;
		else if (hflags_d[1]) status = StIgnored;
		else if (err_d || !end_d || !pres_d[0]) status = StMalformed;
		else status = StAccepted;
	end

	// Per-packet state; a last beat clears it for the next payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hflags_q <= '0;
			xid_q <= '0;
			yaddr_q <= '0;
			cookie_q <= '0;
			vshift_q <= '0;
			phase_q <= PH_CODE;
			code_q <= '0;
			remain_q <= '0;
			vals_q <= '0;
			dns_q <= '0;
			pres_q <= '0;
			dns_pres_q <= 1'b0;
			dcnt_q <= '0;
			err_q <= 1'b0;
			end_q <= 1'b0;
			sum_valid <= 1'b0;
		end else begin
			sum_valid <= in_beat && last;
			if (in_beat && last) begin
				sum.status <= status;
				sum.your_addr <= yaddr_d;
				sum.values <= vals_d;
				sum.present <= pres_d;
				sum.dns_present <= dns_pres_d;
				sum.dns_count <= dcnt_d;
				sum.dns <= dns_d;
			end
			if (in_beat) begin
				if (last) begin
					pos_q <= '0;
					hflags_q <= '0;
					xid_q <= '0;
					yaddr_q <= '0;
					cookie_q <= '0;
					vshift_q <= '0;
					phase_q <= PH_CODE;
					code_q <= '0;
					remain_q <= '0;
					vals_q <= '0;
					dns_q <= '0;
					pres_q <= '0;
					dns_pres_q <= 1'b0;
					dcnt_q <= '0;
					err_q <= 1'b0;
					end_q <= 1'b0;
				end else begin
					if (pos_q != 16'hffff) pos_q <= pos_q + 16'd1;
					hflags_q <= hflags_d;
					xid_q <= xid_d;
					yaddr_q <= yaddr_d;
					cookie_q <= cookie_d;
					vshift_q <= vshift_d;
					phase_q <= phase_d;
					code_q <= code_d;
					remain_q <= remain_d;
					vals_q <= vals_d;
					dns_q <= dns_d;
					pres_q <= pres_d;
					dns_pres_q <= dns_pres_d;
					dcnt_q <= dcnt_d;
					err_q <= err_d;
					end_q <= end_d;
				end
			end
		end
	end

endmodule

### hdl/dhcp_emitter.sv
module dhcp_emitter (
	input logic clk,
	input logic arst_n,
	input logic sum_valid,
	input dhcp_pkg::summary_t sum,
	output logic full,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] field_kind,
	output logic [2:0] field_index,
	output logic [31:0] field_value,
	output logic end_of_packet
);
	import dhcp_pkg::*;

	localparam int StepW = $clog2(8 + MaxDns + 1);

	// Two-entry summary queue; head is walked one result per beat.
	summary_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic [StepW-1:0] step_q;
	summary_t head;
	logic busy;
	logic take, fin, vis;
	logic [StepW-1:0] dstep;

	assign head = q_q[rd_q];
	assign busy = cnt_q != 2'd0;
	assign take = out_valid && out_ready;
	assign dstep = step_q - StepW'(8);

	// The queue counts as full when a summary on its way in would take the last slot.
	assign full = (cnt_q == 2'd2) || (cnt_q == 2'd1 && sum_valid);

	// Is the current step a result that this summary emits?
	always_comb begin
		vis = 1'b0;
		field_kind = KindStatus;
		field_index = '0;
		field_value = '0;
		end_of_packet = 1'b0;
		if (head.status != StAccepted || step_q == StepW'(8 + MaxDns)) begin
			vis = 1'b1;
			field_value = {30'd0, head.status};
			end_of_packet = 1'b1;
		end else if (step_q == '0) begin
			vis = 1'b1;
			field_kind = KindMsgType;
			field_value = head.values[0];
		end else if (step_q == StepW'(1)) begin
			vis = 1'b1;
			field_kind = KindYourAddr;
			field_value = head.your_addr;
		end else if (step_q < StepW'(8)) begin
			vis = head.present[step_q[2:0] - 3'd1];
			field_kind = 4'(step_q) + 4'd1;
			field_value = head.values[step_q[2:0] - 3'd1];
		end else begin
			vis = head.dns_present && (dstep < StepW'(head.dns_count));
			field_kind = KindDns;
			field_index = 3'(dstep);
			field_value = head.dns[DnsIdxW'(dstep)];
		end
	end

	assign out_valid = busy && vis;
	assign fin = busy && vis && end_of_packet && out_ready;

	always_ff @(posedge clk) begin
		if (sum_valid) q_q[wr_q] <= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (sum_valid) wr_q <= ~wr_q;
			cnt_q <= cnt_q + {1'b0, sum_valid} - {1'b0, fin};
			if (fin) begin
				rd_q <= ~rd_q;
				step_q <= '0;
			end else if (busy && (take || !vis)) begin
				step_q <= step_q + StepW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("summary queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_value))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> step_q == '0)
		else $error("step not cleared after status");

endmodule

### hdl/dhcp_reply_parser_top.sv
// DHCP reply parser.
// Input channel: one payload byte per beat (data_byte, last) on in_valid/in_ready.
// Output channel: field results (field_kind, field_index, field_value,
// end_of_packet) on out_valid/out_ready. An accepted reply yields message
// type, your address, the present options and the DNS entries, then a
// status result with end_of_packet set; any other reply yields status only.
// Configuration: cfg_we with cfg_index 0 (expected xid) or 1 (client MAC),
// written while idle.
// Bytes are taken one per cycle while in_ready is high. The first result of
// a packet appears once its summary is registered in the parser and then
// written into the emitter queue. The emitter walks one step per cycle while
// the receiver is ready; an absent option or an unused DNS slot costs an idle
// step, so an accepted packet walks 8 + MaxDns + 1 = 13 steps. Packet summaries
// wait in a two-entry queue, so the parser keeps taking bytes while results
// drain; in_ready drops while the queue, counting a summary on its way in,
// holds two packets. A stalled receiver holds the current result unchanged.
// Reset clears all per-packet state, the queue and both registers.
module dhcp_reply_parser_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic last,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] field_kind,
	output logic [2:0] field_index,
	output logic [31:0] field_value,
	output logic end_of_packet,
	input logic cfg_we,
	input logic cfg_index,
	input logic [47:0] cfg_data
);
	import dhcp_pkg::*;

	logic [31:0] xid_q;
	logic [47:0] mac_q;
	logic sum_valid, full;
	summary_t sum;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xid_q <= '0;
			mac_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) xid_q <= cfg_data[31:0];
			else mac_q <= cfg_data;
		end
	end

	// Hold off input bytes while no slot is left for another packet summary.
	assign in_ready = !full;

	dhcp_parser u_parser (
		.clk, .arst_n,
		.in_beat(in_valid && in_ready),
		.data_byte, .last,
		.expected_xid(xid_q), .client_mac(mac_q),
		.sum_valid, .sum
	);

	dhcp_emitter u_emit (
		.clk, .arst_n, .sum_valid, .sum, .full,
		.out_valid, .out_ready, .field_kind, .field_index, .field_value, .end_of_packet
	);

endmodule
